/* rtl/chc_pkg.sv */
// Shared constants and types of the canonical Huffman code assigner.
package chc_pkg;

   localparam int DEF_MAX_SYMBOLS  = 512;
   localparam int DEF_MAX_CODE_LEN = 15;

   localparam int OP_W    = 2;
   localparam int SYM_W   = 9;
   localparam int LEN_W   = 4;
   localparam int CODE_W  = 15;
   localparam int NEXT_W  = 16;
   localparam int CNT_W   = 10;
   localparam int HIST_N  = 16;
   localparam int ROOM_W  = 17;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   localparam logic [CNT_W-1:0] SYMBOL_COUNT_RESET = 10'd288;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COUNT,
      ST_STEP,
      ST_ASSIGN,
      ST_DONE
   } state_type;

endpackage

/* rtl/chc_ram.sv */
// Simple dual-port RAM: one write port, one registered read port.
module chc_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/canonical_huffman_code_assigner.sv */
// Canonical Huffman code assigner: top level with length and code stores.
//
// After reset the block runs a clearing pass over the length store and
// accepts no request beat meanwhile (csr writes are taken at any time).
// Loads are written to the length store as they are accepted. Reads sustain
// one beat per cycle while the response stream is not stalled, the response
// passing through the registered read port of the two stores and then the
// response register. A build walks the length store twice through its single
// read port: the first walk fills the length histogram, a stepping pass then
// derives the first code of each length, the second walk hands out codes,
// and the result is posted once the response register is free.
module canonical_huffman_code_assigner #(
   parameter int MAX_SYMBOLS  = chc_pkg::DEF_MAX_SYMBOLS,
   parameter int MAX_CODE_LEN = chc_pkg::DEF_MAX_CODE_LEN
) (
   input  logic                              clock,
   input  logic                              reset,
   // csr write: symbol_count
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [chc_pkg::CNT_W-1:0]         csr_wdata,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [chc_pkg::REQ_DATA_W-1:0]    req_tdata,  // symbol, code_len_in, zero pad
   input  logic [chc_pkg::OP_W-1:0]          req_tuser,  // op
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [chc_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // code_value, code_len_out,
                                                         // oversubscribed, used_symbols, pad
   output logic                              rsp_tuser   // is_build_result
);

   import chc_pkg::*;

   localparam int AW      = $clog2(MAX_SYMBOLS);
   localparam int WALK_W  = $clog2(MAX_SYMBOLS + 1);
   localparam int XW      = ((AW > SYM_W) ? AW : SYM_W) + 1;
   localparam int CW      = (WALK_W > CNT_W) ? WALK_W : CNT_W;
   localparam int LEN_TOP = (MAX_CODE_LEN < 15) ? MAX_CODE_LEN : 15;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]  symbol_count_ff, symbol_count_in;
   logic [WALK_W-1:0] idx_ff, idx_in;
   logic [WALK_W-1:0] walk_ff, walk_in;
   logic              pv_ff, pv_in;
   logic [AW-1:0]     paddr_ff, paddr_in;
   logic [CNT_W-1:0]  hist_ff [HIST_N];
   logic [CNT_W-1:0]  hist_in [HIST_N];
   logic [NEXT_W-1:0] next_ff [HIST_N];
   logic [NEXT_W-1:0] next_in [HIST_N];
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [LEN_W-1:0]  step_ff, step_in;
   logic [NEXT_W-1:0] code_ff, code_in;
   logic signed [ROOM_W-1:0] room_ff, room_in;
   logic              over_ff, over_in;

   logic              rd_valid_ff, rd_valid_in;
   logic              rd_oor_ff, rd_oor_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0] rsp_code_ff, rsp_code_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic              rsp_build_ff, rsp_build_in;
   logic              rsp_over_ff, rsp_over_in;
   logic [CNT_W-1:0]  rsp_used_ff, rsp_used_in;

   logic              req_accept, rsp_accept, rd_move, post_build, walk_issue;
   logic [OP_W-1:0]   req_op;
   logic [SYM_W-1:0]  req_sym;
   logic [LEN_W-1:0]  req_len, req_len_sat;
   logic [XW-1:0]     sym_x;
   logic              sym_ok;
   logic [CW-1:0]     sc_x;
   logic [WALK_W-1:0] walk_sel;

   logic              len_wr_en, len_rd_en, code_wr_en, code_rd_en;
   logic [AW-1:0]     len_wr_addr, len_rd_addr;
   logic [LEN_W-1:0]  len_wr_data, len_rd_data;
   logic [CODE_W-1:0] code_wr_data, code_rd_data;

   logic [NEXT_W-1:0] cur_next, len_mask, code_step;
   logic signed [ROOM_W-1:0] room_step;

   assign req_op      = req_tuser;
   assign req_sym     = req_tdata[SYM_W-1:0];
   assign req_len     = req_tdata[SYM_W+LEN_W-1:SYM_W];
   assign req_len_sat = (req_len > LEN_W'(LEN_TOP)) ? LEN_W'(LEN_TOP) : req_len;
   assign sym_x       = XW'(req_sym);
   assign sym_ok      = sym_x < XW'(MAX_SYMBOLS);
   assign sc_x        = CW'(symbol_count_ff);
   assign walk_sel    = (sc_x > CW'(MAX_SYMBOLS)) ? WALK_W'(MAX_SYMBOLS)
                                                  : WALK_W'(symbol_count_ff);

   assign rsp_accept  = rsp_valid_ff && rsp_tready;
   assign rd_move     = rd_valid_ff && (!rsp_valid_ff || rsp_accept);
   assign req_accept  = req_tvalid && req_tready;
   assign post_build  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_accept);
   assign walk_issue  = ((state_ff == ST_COUNT) || (state_ff == ST_ASSIGN))
                        && (idx_ff != walk_ff);

   assign cur_next  = next_ff[len_rd_data];
   assign len_mask  = (NEXT_W'(1) << len_rd_data) - NEXT_W'(1);
   assign code_step = NEXT_W'((code_ff + NEXT_W'(hist_ff[step_ff - LEN_W'(1)])) << 1);
   assign room_step = (room_ff <<< 1) - ROOM_W'(hist_ff[step_ff]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (idx_ff == WALK_W'(MAX_SYMBOLS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_accept && (req_op == OP_BUILD)) state_in = ST_COUNT;
         end
         ST_COUNT: begin
            if ((idx_ff == walk_ff) && !pv_ff) state_in = ST_STEP;
         end
         ST_STEP: begin
            if (step_ff == LEN_W'(HIST_N - 1)) state_in = ST_ASSIGN;
         end
         ST_ASSIGN: begin
            if ((idx_ff == walk_ff) && !pv_ff) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (post_build) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // control outputs and memory ports
   always_comb begin
      req_tready   = (state_ff == ST_IDLE) && (!rd_valid_ff || rd_move);
      csr_ready    = 1'b1;
      len_wr_en    = 1'b0;
      len_wr_addr  = sym_x[AW-1:0];
      len_wr_data  = req_len_sat;
      len_rd_en    = 1'b0;
      len_rd_addr  = sym_x[AW-1:0];
      code_rd_en   = 1'b0;
      code_wr_en   = 1'b0;
      code_wr_data = CODE_W'(cur_next & len_mask);
      case (state_ff)
         ST_CLEAR: begin
            len_wr_en   = 1'b1;
            len_wr_addr = idx_ff[AW-1:0];
            len_wr_data = '0;
         end
         ST_IDLE: begin
            if (req_accept && (req_op == OP_LOAD) && sym_ok) len_wr_en = 1'b1;
            if (req_accept && (req_op == OP_READ)) begin
               len_rd_en  = 1'b1;
               code_rd_en = 1'b1;
            end
         end
         ST_COUNT: begin
            len_rd_en   = walk_issue;
            len_rd_addr = idx_ff[AW-1:0];
         end
         ST_ASSIGN: begin
            len_rd_en   = walk_issue;
            len_rd_addr = idx_ff[AW-1:0];
            code_wr_en  = pv_ff && (len_rd_data != '0);
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      symbol_count_in = csr_valid ? csr_wdata : symbol_count_ff;
      idx_in   = idx_ff;
      walk_in  = walk_ff;
      pv_in    = 1'b0;
      paddr_in = idx_ff[AW-1:0];
      hist_in  = hist_ff;
      next_in  = next_ff;
      used_in  = used_ff;
      step_in  = step_ff;
      code_in  = code_ff;
      room_in  = room_ff;
      over_in  = over_ff;

      if (walk_issue) begin
         pv_in  = 1'b1;
         idx_in = idx_ff + WALK_W'(1);
      end

      case (state_ff)
         ST_CLEAR: begin
            idx_in = (idx_ff == WALK_W'(MAX_SYMBOLS - 1)) ? '0 : idx_ff + WALK_W'(1);
         end
         ST_IDLE: begin
            if (req_accept && (req_op == OP_BUILD)) begin
               idx_in  = '0;
               walk_in = walk_sel;
               used_in = '0;
               for (int k = 0; k < HIST_N; k++) hist_in[k] = '0;
            end
         end
         ST_COUNT: begin
            if (pv_ff && (len_rd_data != '0)) begin
               hist_in[len_rd_data] = hist_ff[len_rd_data] + CNT_W'(1);
               used_in = used_ff + CNT_W'(1);
            end
            if ((idx_ff == walk_ff) && !pv_ff) begin
               step_in = LEN_W'(1);
               code_in = '0;
               room_in = ROOM_W'(1);
               over_in = 1'b0;
            end
         end
         ST_STEP: begin
            next_in[step_ff] = code_step;
            code_in = code_step;
            if (!over_ff && (step_ff <= LEN_W'(LEN_TOP))) begin
               room_in = room_step;
               if (room_step < 0) over_in = 1'b1;
            end
            step_in = step_ff + LEN_W'(1);
            if (step_ff == LEN_W'(HIST_N - 1)) idx_in = '0;
         end
         ST_ASSIGN: begin
            if (pv_ff && (len_rd_data != '0)) begin
               next_in[len_rd_data] = cur_next + NEXT_W'(1);
            end
         end
         default: begin
         end
      endcase

      rd_valid_in = rd_valid_ff && !rd_move;
      rd_oor_in   = rd_oor_ff;
      if (req_accept && (req_op == OP_READ)) begin
         rd_valid_in = 1'b1;
         rd_oor_in   = !sym_ok;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_accept;
      rsp_code_in  = rsp_code_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_build_in = rsp_build_ff;
      rsp_over_in  = rsp_over_ff;
      rsp_used_in  = rsp_used_ff;
      if (rd_move) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = rd_oor_ff ? '0 : code_rd_data;
         rsp_len_in   = rd_oor_ff ? '0 : len_rd_data;
         rsp_build_in = 1'b0;
         rsp_over_in  = 1'b0;
         rsp_used_in  = '0;
      end else if (post_build) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = '0;
         rsp_len_in   = '0;
         rsp_build_in = 1'b1;
         rsp_over_in  = over_ff;
         rsp_used_in  = used_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         symbol_count_ff <= SYMBOL_COUNT_RESET;
         idx_ff          <= '0;
         pv_ff           <= 1'b0;
         rd_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         symbol_count_ff <= symbol_count_in;
         idx_ff          <= idx_in;
         pv_ff           <= pv_in;
         rd_valid_ff     <= rd_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff      <= walk_in;
      paddr_ff     <= paddr_in;
      hist_ff      <= hist_in;
      next_ff      <= next_in;
      used_ff      <= used_in;
      step_ff      <= step_in;
      code_ff      <= code_in;
      room_ff      <= room_in;
      over_ff      <= over_in;
      rd_oor_ff    <= rd_oor_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_build_ff <= rsp_build_in;
      rsp_over_ff  <= rsp_over_in;
      rsp_used_ff  <= rsp_used_in;
   end

   chc_ram #(
      .WIDTH (LEN_W),
      .DEPTH (MAX_SYMBOLS)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_wr_en),
      .wr_addr (len_wr_addr),
      .wr_data (len_wr_data),
      .rd_en   (len_rd_en),
      .rd_addr (len_rd_addr),
      .rd_data (len_rd_data)
   );

   chc_ram #(
      .WIDTH (CODE_W),
      .DEPTH (MAX_SYMBOLS)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (code_wr_en),
      .wr_addr (paddr_ff),
      .wr_data (code_wr_data),
      .rd_en   (code_rd_en),
      .rd_addr (sym_x[AW-1:0]),
      .rd_data (code_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_build_ff;
   assign rsp_tdata  = {2'b00, rsp_used_ff, rsp_over_ff, rsp_len_ff, rsp_code_ff};

endmodule

/* tb/sv/canonical_huffman_code_assigner_tb.sv */
// Self-checking testbench for the canonical Huffman code assigner.
`timescale 1ns / 1ps

module canonical_huffman_code_assigner_tb;
   import chc_pkg::*;

   localparam int NSYM = DEF_MAX_SYMBOLS;
   localparam int MAXL = DEF_MAX_CODE_LEN;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 2 * NSYM + 64;
   localparam int NPHASE = 11;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [SYM_W-1:0] sym;
      logic [LEN_W-1:0] len;
   } huff_req_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
      logic              build;
      logic              over;
      logic [CNT_W-1:0]  used;
   } huff_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CNT_W-1:0]      csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]       req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   canonical_huffman_code_assigner uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   // predictor state
   logic [LEN_W-1:0]  len_mem  [NSYM];
   logic [CODE_W-1:0] code_mem [NSYM];
   logic [CNT_W-1:0]  sym_count = SYMBOL_COUNT_RESET;
   huff_rsp_type      code_answers [$];

   // stimulus-side shadow, used only to keep reads on built entries
   logic [LEN_W-1:0]  gen_len     [NSYM];
   bit                gen_written [NSYM];
   int                gen_count = SYMBOL_COUNT_RESET;

   huff_req_type      req_pending [$];
   huff_req_type      drv_item;
   int                beats_queued = 0;
   int                beats_taken = 0;
   int                send_idle_pct = 0;
   int                rsp_stall_pct = 0;
   int                errors = 0;

   initial begin
      for (int i = 0; i < NSYM; i++) begin
         len_mem[i] = '0;
         code_mem[i] = '0;
         gen_len[i] = '0;
         gen_written[i] = 1'b0;
      end
   end

   task automatic huff_predict(input huff_req_type r);
      int        walk;
      int        used;
      int        c;
      longint    room;
      logic      over;
      logic [15:0] code;
      logic [CNT_W-1:0] hist [HIST_N];
      logic [15:0] next_code [HIST_N];
      huff_rsp_type a;
      case (r.op)
         OP_LOAD: begin
            len_mem[r.sym] = (r.len > MAXL) ? LEN_W'(MAXL) : r.len;
         end
         OP_BUILD: begin
            walk = (sym_count > NSYM) ? NSYM : int'(sym_count);
            for (int l = 0; l < HIST_N; l++) hist[l] = '0;
            used = 0;
            for (int i = 0; i < walk; i++) begin
               if (len_mem[i] != 0) begin
                  hist[len_mem[i]] = hist[len_mem[i]] + 1'b1;
                  used++;
               end
            end
            room = 1;
            over = 1'b0;
            for (int l = 1; l <= MAXL && l < HIST_N; l++) begin
               room = room * 2 - longint'(hist[l]);
               if (room < 0) over = 1'b1;
            end
            code = '0;
            next_code[0] = '0;
            for (int l = 1; l < HIST_N; l++) begin
               code = (code + hist[l-1]) << 1;
               next_code[l] = code;
            end
            for (int i = 0; i < walk; i++) begin
               if (len_mem[i] != 0) begin
                  c = next_code[len_mem[i]];
                  code_mem[i] = CODE_W'(c & ((1 << len_mem[i]) - 1));
                  next_code[len_mem[i]] = next_code[len_mem[i]] + 1'b1;
               end
            end
            a = '{code: '0, len: '0, build: 1'b1, over: over, used: CNT_W'(used)};
            code_answers.push_back(a);
         end
         OP_READ: begin
            a = '{code: code_mem[r.sym], len: len_mem[r.sym], build: 1'b0, over: 1'b0,
                  used: '0};
            code_answers.push_back(a);
         end
         default: ;
      endcase
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            huff_predict(drv_item);
            beats_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               drv_item = req_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {3'b000, drv_item.len, drv_item.sym};
               req_tuser <= drv_item.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      huff_rsp_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[14:0], rsp_tdata[18:15], rsp_tuser, rsp_tdata[19],
                   rsp_tdata[29:20]};
            if (code_answers.size() == 0) begin
               errors++;
               $display("%0t: expected no beat, actual %h %0d %0d %0d %0d",
                        $time, got.code, got.len, got.build, got.over, got.used);
            end else begin
               want = code_answers.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t: mismatch expected %h %0d %0d %0d %0d actual %h %0d %0d %0d %0d",
                           $time, want.code, want.len, want.build, want.over, want.used,
                           got.code, got.len, got.build, got.over, got.used);
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic push_item(input logic [OP_W-1:0] op, input int sym, input int len);
      int walk;
      req_pending.push_back('{op: op, sym: SYM_W'(sym), len: LEN_W'(len)});
      beats_queued++;
      if (op == OP_LOAD) begin
         gen_len[sym] = LEN_W'(len);
      end else if (op == OP_BUILD) begin
         walk = (gen_count > NSYM) ? NSYM : gen_count;
         for (int i = 0; i < walk; i++)
            if (gen_len[i] != 0) gen_written[i] = 1'b1;
      end
   endtask

   function automatic int pick_built_symbol();
      int start;
      start = $urandom_range(NSYM - 1);
      for (int k = 0; k < NSYM; k++)
         if (gen_written[(start + k) % NSYM]) return (start + k) % NSYM;
      return -1;
   endfunction

   task automatic push_read_any();
      int s;
      s = pick_built_symbol();
      if (s >= 0) push_item(OP_READ, s, $urandom_range(15));
   endtask

   // loads every walked symbol, builds, reads back every built one
   task automatic frame_complete(input int w);
      int lens_set [$];
      int slot [];
      int perm [];
      int s, idx, l, j, tmp, guard;
      slot = new[w];
      perm = new[w];
      for (int i = 0; i < w; i++) begin
         slot[i] = 0;
         perm[i] = i;
      end
      for (int i = w - 1; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = perm[i];
         perm[i] = perm[j];
         perm[j] = tmp;
      end
      if ($urandom_range(99) < 30) begin
         for (int i = 0; i < w; i++)
            slot[i] = ($urandom_range(99) < 40) ? 0 : $urandom_range(1, 15);
      end else begin
         s = $urandom_range(1, w);
         if (s == 1) begin
            lens_set.push_back($urandom_range(1, 15));
         end else begin
            lens_set.push_back(1);
            lens_set.push_back(1);
         end
         guard = 0;
         while (lens_set.size() < s && guard < 400) begin
            idx = $urandom_range(lens_set.size() - 1);
            l = lens_set[idx];
            if (l < MAXL) begin
               lens_set[idx] = l + 1;
               lens_set.push_back(l + 1);
            end
            guard++;
         end
         // shorten one code to overfill the code space now and then
         if (lens_set.size() >= 2 && $urandom_range(99) < 20 && lens_set[0] > 1)
            lens_set[0] = lens_set[0] - 1;
         for (int k = 0; k < lens_set.size(); k++) slot[perm[k]] = lens_set[k];
      end
      for (int i = 0; i < w; i++) push_item(OP_LOAD, perm[w - 1 - i], slot[perm[w - 1 - i]]);
      push_item(OP_BUILD, $urandom_range(NSYM - 1), $urandom_range(15));
      for (int i = 0; i < w; i++) begin
         if (gen_written[perm[i]]) push_item(OP_READ, perm[i], $urandom_range(15));
         if ($urandom_range(99) < 5) push_item(OP_UNUSED, $urandom_range(NSYM - 1),
                                               $urandom_range(15));
      end
      if ($urandom_range(99) < 30) begin
         s = perm[$urandom_range(w - 1)];
         push_item(OP_LOAD, s, $urandom_range(15));
         if (gen_written[s]) push_item(OP_READ, s, 0);
      end
   endtask

   // a few loads, a build, reads of built entries
   task automatic frame_sparse(input int w);
      int m, s;
      m = $urandom_range(1, 16);
      for (int k = 0; k < m; k++) begin
         if (w == 0 || $urandom_range(99) < 15) s = $urandom_range(NSYM - 1);
         else s = $urandom_range(w - 1);
         push_item(OP_LOAD, s, $urandom_range(15));
      end
      push_item(OP_BUILD, $urandom_range(NSYM - 1), $urandom_range(15));
      for (int k = 0; k < m; k++) push_read_any();
   endtask

   task automatic noise(input int n);
      for (int k = 0; k < n; k++) begin
         case (OP_W'($urandom_range(3)))
            OP_LOAD:  push_item(OP_LOAD, $urandom_range(NSYM - 1), $urandom_range(15));
            OP_BUILD: push_item(OP_BUILD, $urandom_range(NSYM - 1), $urandom_range(15));
            OP_READ:  push_read_any();
            default:  push_item(OP_UNUSED, $urandom_range(NSYM - 1), $urandom_range(15));
         endcase
      end
   endtask

   task automatic wait_drained();
      while (beats_taken != beats_queued || code_answers.size() != 0) @(posedge clock);
   endtask

   task automatic write_symbol_count(input int v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= CNT_W'(v);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sym_count = CNT_W'(v);
      gen_count = v;
   endtask

   initial begin
      int ph_count [NPHASE];
      int ph_send  [NPHASE];
      int ph_stall [NPHASE];
      int ph_items [NPHASE];
      int start, w, r;

      ph_count = '{0, 1, 2, 9, 40, 512, 1023, 17, 30, 288, 48};
      ph_send  = '{58, 0, 16, 0, 58, 0, 16, 0, 16, 0, 58};
      ph_stall = '{0, 58, 16, 0, 0, 58, 16, 58, 16, 0, 0};
      ph_items = '{50, 70, 100, 170, 170, 130, 130, 170, 170, 100, 90};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed beats at the reset symbol count
      @(negedge clock);
      push_item(OP_UNUSED, 511, 15);
      push_item(OP_LOAD, 0, 1);
      push_item(OP_LOAD, 1, 15);
      push_item(OP_LOAD, 287, 2);
      push_item(OP_LOAD, 511, 15);
      push_item(OP_LOAD, 256, 8);
      push_item(OP_LOAD, 2, 0);
      push_item(OP_BUILD, 0, 0);
      push_item(OP_READ, 0, 0);
      push_item(OP_READ, 1, 0);
      push_item(OP_READ, 287, 0);
      push_item(OP_READ, 256, 0);
      push_item(OP_LOAD, 3, 1);
      push_item(OP_LOAD, 4, 1);
      push_item(OP_BUILD, 511, 15);
      push_item(OP_READ, 3, 0);
      push_item(OP_READ, 4, 0);
      push_item(OP_READ, 0, 0);
      push_item(OP_LOAD, 0, 5);
      push_item(OP_READ, 0, 15);
      push_item(OP_UNUSED, 0, 0);
      wait_drained();

      for (int p = 0; p < NPHASE; p++) begin
         repeat (SETTLE_CYCLES) @(posedge clock);
         write_symbol_count(ph_count[p]);
         send_idle_pct = ph_send[p];
         rsp_stall_pct = ph_stall[p];
         @(negedge clock);
         start = beats_queued;
         w = (ph_count[p] > NSYM) ? NSYM : ph_count[p];
         while (beats_queued - start < ph_items[p]) begin
            r = $urandom_range(99);
            if (w >= 1 && w <= 48 && r < 70) frame_complete(w);
            else if (r < 90) frame_sparse(w);
            else noise($urandom_range(1, 6));
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && code_answers.size() == 0) begin
         $display("canonical_huffman_code_assigner regression: pass");
      end else begin
         $display("canonical_huffman_code_assigner regression: fail");
      end
      $finish;
   end

   initial begin
      #(20_000_000);
      $display("canonical_huffman_code_assigner regression: fail");
      $finish;
   end

endmodule
